// File: rtl/doubly_linked_list_engine_assert.svh
// Assertion macros for the list engine checker.
`ifndef DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH
`define DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH

// Clocked check, held off while reset is active.
`define DLLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define DLLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/dlle_pkg.sv
// Types and constants of the doubly linked list engine.
package dlle_pkg;

    localparam int NODES       = 16;
    localparam int VALUE_BITS  = 32;
    localparam int HANDLE_BITS = $clog2(NODES);
    localparam int COUNT_BITS  = 4;
    localparam int CMD_BITS    = 3;
    localparam int STATUS_BITS = 3;
    localparam int WM_BITS     = $clog2(NODES + 1);
    localparam int STEP_BITS   = $clog2(NODES + 1);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_INSERT     = 3'd4,
        CMD_ERASE      = 3'd5,
        CMD_FIND       = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STS_OK         = 3'd0,
        STS_EMPTY      = 3'd1,
        STS_FULL       = 3'd2,
        STS_BAD_HANDLE = 3'd3,
        STS_NOT_FOUND  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_LINK,
        ST_INS_FIX,
        ST_UNL_A,
        ST_UNL_B,
        ST_FIND,
        ST_RESP
    } state_t;

endpackage

// File: rtl/doubly_linked_list_engine.sv
// Circular doubly linked list engine over a fixed node pool with a sentinel.
//
// A command is taken when start is high and busy is low; busy then stays high
// until the result has been shown. The result appears on the result ports for
// exactly one cycle with done high and cannot be held off, so capture it then.
// Push and insert go DISPATCH, INS_LINK, INS_FIX, RESP; pop and erase go
// DISPATCH, UNL_A, UNL_B, RESP, set by the single write port of each link
// memory (two link updates per memory are done one after the other). Errors
// and the unused command code go from DISPATCH straight to RESP. Find walks
// at most NODES nodes and reads one node per cycle through the value
// and next-link memory read ports. A new command can be taken in the cycle
// after done. No clearing pass runs after reset: the sentinel links sit in
// registers and pool slots come from the free list, then a fill watermark.
module doubly_linked_list_engine (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [dlle_pkg::CMD_BITS-1:0]           cmd,
    input  logic [dlle_pkg::HANDLE_BITS-1:0]        node_handle,
    input  logic signed [dlle_pkg::VALUE_BITS-1:0]  value,
    output logic                                    done,
    output logic [dlle_pkg::STATUS_BITS-1:0]        status,
    output logic [dlle_pkg::HANDLE_BITS-1:0]        result_handle,
    output logic signed [dlle_pkg::VALUE_BITS-1:0]  result_value,
    output logic [dlle_pkg::COUNT_BITS-1:0]         element_count_out
);

    localparam int HB = dlle_pkg::HANDLE_BITS;
    localparam int VB = dlle_pkg::VALUE_BITS;

    // control state
    dlle_pkg::state_t              state_reg, state_next;
    logic [HB-1:0]                 head_reg, head_next;
    logic [HB-1:0]                 tail_reg, tail_next;
    logic [HB-1:0]                 free_head_reg, free_head_next;
    logic [dlle_pkg::WM_BITS-1:0]  wm_reg, wm_next;
    logic [dlle_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic [dlle_pkg::NODES-1:0]    in_use_reg, in_use_next;
    logic [dlle_pkg::STEP_BITS-1:0] steps_reg, steps_next;

    // transaction payload and working registers
    dlle_pkg::cmd_t                cmd_reg;
    logic [HB-1:0]                 h_reg;
    logic [VB-1:0]                 v_reg;
    logic [HB-1:0]                 pos_reg, pos_next;
    logic [HB-1:0]                 n_reg, n_next;
    logic [HB-1:0]                 p_reg, p_next;
    logic [HB-1:0]                 cur_reg, cur_next;
    dlle_pkg::status_t             status_reg, status_next;
    logic [HB-1:0]                 rhandle_reg, rhandle_next;
    logic [VB-1:0]                 rvalue_reg, rvalue_next;

    // node memories; entry 0 of the link memories is unused, the sentinel
    // links live in head_reg and tail_reg
    logic [HB-1:0] nx_mem [dlle_pkg::NODES];
    logic [HB-1:0] pv_mem [dlle_pkg::NODES];
    logic [VB-1:0] val_mem [dlle_pkg::NODES];

    logic          nx_we, pv_we, val_we;
    logic [HB-1:0] nx_waddr, pv_waddr, val_waddr;
    logic [HB-1:0] nx_wdata, pv_wdata;
    logic [VB-1:0] val_wdata;
    logic [HB-1:0] nx_raddr, pv_raddr, val_raddr;
    logic [HB-1:0] nx_rdata_reg, pv_rdata_reg;
    logic [VB-1:0] val_rdata_reg;

    logic          h_ok;
    logic          pool_full;
    logic [HB-1:0] ins_pos;
    logic [HB-1:0] new_node;
    logic [HB-1:0] pop_node;
    logic [HB-1:0] ins_prev;
    logic [dlle_pkg::STEP_BITS-1:0] steps_inc;

    assign h_ok      = (32'(h_reg) < dlle_pkg::NODES);
    assign pool_full = (free_head_reg == '0) && (32'(wm_reg) >= dlle_pkg::NODES);
    assign ins_pos   = (cmd_reg == dlle_pkg::CMD_PUSH_BACK)  ? '0 :
                       (cmd_reg == dlle_pkg::CMD_PUSH_FRONT) ? head_reg : h_reg;
    assign new_node  = (free_head_reg != '0) ? free_head_reg : wm_reg[HB-1:0];
    assign pop_node  = (cmd_reg == dlle_pkg::CMD_POP_BACK) ? tail_reg : head_reg;
    assign ins_prev  = (pos_reg == '0) ? tail_reg : pv_rdata_reg;
    assign steps_inc = steps_reg + dlle_pkg::STEP_BITS'(1);

    assign busy              = (state_reg != dlle_pkg::ST_IDLE);
    assign done              = (state_reg == dlle_pkg::ST_RESP);
    assign status            = status_reg;
    assign result_handle     = rhandle_reg;
    assign result_value      = rvalue_reg;
    assign element_count_out = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dlle_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            free_head_reg <= '0;
            wm_reg        <= dlle_pkg::WM_BITS'(1);
            count_reg     <= '0;
            in_use_reg    <= '0;
            steps_reg     <= '0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_head_reg <= free_head_next;
            wm_reg        <= wm_next;
            count_reg     <= count_next;
            in_use_reg    <= in_use_next;
            steps_reg     <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= dlle_pkg::cmd_t'(cmd);
            h_reg   <= node_handle;
            v_reg   <= value;
        end
        pos_reg     <= pos_next;
        n_reg       <= n_next;
        p_reg       <= p_next;
        cur_reg     <= cur_next;
        status_reg  <= status_next;
        rhandle_reg <= rhandle_next;
        rvalue_reg  <= rvalue_next;
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            nx_mem[nx_waddr] <= nx_wdata;
        end
        nx_rdata_reg <= nx_mem[nx_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pv_we)
        begin
            pv_mem[pv_waddr] <= pv_wdata;
        end
        pv_rdata_reg <= pv_mem[pv_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        val_rdata_reg <= val_mem[val_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        wm_next        = wm_reg;
        count_next     = count_reg;
        in_use_next    = in_use_reg;
        steps_next     = steps_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        p_next         = p_reg;
        cur_next       = cur_reg;
        status_next    = status_reg;
        rhandle_next   = rhandle_reg;
        rvalue_next    = rvalue_reg;
        nx_we          = 1'b0;
        pv_we          = 1'b0;
        val_we         = 1'b0;
        nx_waddr       = '0;
        pv_waddr       = '0;
        val_waddr      = '0;
        nx_wdata       = '0;
        pv_wdata       = '0;
        val_wdata      = '0;
        nx_raddr       = '0;
        pv_raddr       = '0;
        val_raddr      = '0;

        unique case (state_reg)
            dlle_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = dlle_pkg::ST_DISPATCH;
                end
            end

            dlle_pkg::ST_DISPATCH:
            begin
                status_next  = dlle_pkg::STS_OK;
                rhandle_next = '0;
                rvalue_next  = '0;
                state_next   = dlle_pkg::ST_RESP;
                unique case (cmd_reg)
                    dlle_pkg::CMD_PUSH_BACK, dlle_pkg::CMD_PUSH_FRONT, dlle_pkg::CMD_INSERT:
                    begin
                        if ((cmd_reg == dlle_pkg::CMD_INSERT) &&
                            (!h_ok || ((h_reg != '0) && !in_use_reg[h_reg])))
                        begin
                            status_next = dlle_pkg::STS_BAD_HANDLE;
                        end
                        else if (pool_full)
                        begin
                            status_next = dlle_pkg::STS_FULL;
                        end
                        else
                        begin
                            // fetch free-list successor and predecessor of pos
                            pos_next   = ins_pos;
                            nx_raddr   = free_head_reg;
                            pv_raddr   = ins_pos;
                            state_next = dlle_pkg::ST_INS_LINK;
                        end
                    end

                    dlle_pkg::CMD_POP_BACK, dlle_pkg::CMD_POP_FRONT:
                    begin
                        if ((count_reg == '0) || (head_reg == '0))
                        begin
                            status_next = dlle_pkg::STS_EMPTY;
                        end
                        else
                        begin
                            n_next     = pop_node;
                            nx_raddr   = pop_node;
                            pv_raddr   = pop_node;
                            val_raddr  = pop_node;
                            state_next = dlle_pkg::ST_UNL_A;
                        end
                    end

                    dlle_pkg::CMD_ERASE:
                    begin
                        if (!h_ok || (h_reg == '0) || !in_use_reg[h_reg])
                        begin
                            status_next = dlle_pkg::STS_BAD_HANDLE;
                        end
                        else
                        begin
                            n_next     = h_reg;
                            nx_raddr   = h_reg;
                            pv_raddr   = h_reg;
                            val_raddr  = h_reg;
                            state_next = dlle_pkg::ST_UNL_A;
                        end
                    end

                    dlle_pkg::CMD_FIND:
                    begin
                        status_next = dlle_pkg::STS_NOT_FOUND;
                        if (head_reg != '0)
                        begin
                            cur_next   = head_reg;
                            steps_next = '0;
                            nx_raddr   = head_reg;
                            val_raddr  = head_reg;
                            state_next = dlle_pkg::ST_FIND;
                        end
                    end

                    default:
                    begin
                        // unused code: plain ok answer
                    end
                endcase
            end

            dlle_pkg::ST_INS_LINK:
            begin
                if (free_head_reg != '0)
                begin
                    free_head_next = nx_rdata_reg;
                end
                else
                begin
                    wm_next = wm_reg + dlle_pkg::WM_BITS'(1);
                end
                n_next                = new_node;
                p_next                = ins_prev;
                in_use_next[new_node] = 1'b1;
                val_we                = 1'b1;
                val_waddr             = new_node;
                val_wdata             = v_reg;
                nx_we                 = 1'b1;
                nx_waddr              = new_node;
                nx_wdata              = pos_reg;
                pv_we                 = 1'b1;
                pv_waddr              = new_node;
                pv_wdata              = ins_prev;
                state_next            = dlle_pkg::ST_INS_FIX;
            end

            dlle_pkg::ST_INS_FIX:
            begin
                // hook the new node between p and pos
                if (p_reg == '0)
                begin
                    head_next = n_reg;
                end
                else
                begin
                    nx_we    = 1'b1;
                    nx_waddr = p_reg;
                    nx_wdata = n_reg;
                end
                if (pos_reg == '0)
                begin
                    tail_next = n_reg;
                end
                else
                begin
                    pv_we    = 1'b1;
                    pv_waddr = pos_reg;
                    pv_wdata = n_reg;
                end
                count_next   = count_reg + dlle_pkg::COUNT_BITS'(1);
                status_next  = dlle_pkg::STS_OK;
                rhandle_next = n_reg;
                state_next   = dlle_pkg::ST_RESP;
            end

            dlle_pkg::ST_UNL_A:
            begin
                // bridge the neighbors around n
                if (nx_rdata_reg == '0)
                begin
                    tail_next = pv_rdata_reg;
                end
                else
                begin
                    pv_we    = 1'b1;
                    pv_waddr = nx_rdata_reg;
                    pv_wdata = pv_rdata_reg;
                end
                if (pv_rdata_reg == '0)
                begin
                    head_next = nx_rdata_reg;
                end
                else
                begin
                    nx_we    = 1'b1;
                    nx_waddr = pv_rdata_reg;
                    nx_wdata = nx_rdata_reg;
                end
                status_next  = dlle_pkg::STS_OK;
                rhandle_next = n_reg;
                rvalue_next  = val_rdata_reg;
                state_next   = dlle_pkg::ST_UNL_B;
            end

            dlle_pkg::ST_UNL_B:
            begin
                // push n onto the free list
                nx_we              = 1'b1;
                nx_waddr           = n_reg;
                nx_wdata           = free_head_reg;
                pv_we              = 1'b1;
                pv_waddr           = n_reg;
                pv_wdata           = '0;
                in_use_next[n_reg] = 1'b0;
                free_head_next     = n_reg;
                if (count_reg != '0)
                begin
                    count_next = count_reg - dlle_pkg::COUNT_BITS'(1);
                end
                state_next = dlle_pkg::ST_RESP;
            end

            dlle_pkg::ST_FIND:
            begin
                if (val_rdata_reg == v_reg)
                begin
                    status_next  = dlle_pkg::STS_OK;
                    rhandle_next = cur_reg;
                    rvalue_next  = v_reg;
                    state_next   = dlle_pkg::ST_RESP;
                end
                else
                begin
                    steps_next = steps_inc;
                    if ((nx_rdata_reg == '0) || (32'(steps_inc) >= dlle_pkg::NODES))
                    begin
                        state_next = dlle_pkg::ST_RESP;
                    end
                    else
                    begin
                        // advance to the successor while comparing this one
                        cur_next  = nx_rdata_reg;
                        nx_raddr  = nx_rdata_reg;
                        val_raddr = nx_rdata_reg;
                    end
                end
            end

            dlle_pkg::ST_RESP:
            begin
                state_next = dlle_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = dlle_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/dlle_checker.sv
// Port-level checks of the list engine and their bind to the top level.
`include "doubly_linked_list_engine_assert.svh"

module dlle_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    start,
    input logic                                    busy,
    input logic                                    done,
    input logic [dlle_pkg::STATUS_BITS-1:0]        status,
    input logic [dlle_pkg::HANDLE_BITS-1:0]        result_handle,
    input logic signed [dlle_pkg::VALUE_BITS-1:0]  result_value
);

    // an accepted transaction holds the engine busy in the next cycle
    `DLLE_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accept without busy")

    // the result strobe lasts one cycle and frees the engine after it
    `DLLE_ASSERT(a_done_release, done |=> (!done && !busy), "done not released")

    // a failed command never names a node
    `DLLE_ASSERT(a_err_no_handle,
                 (done && (status != dlle_pkg::STS_OK)) |-> (result_handle == '0),
                 "error result carries a handle")

    // a failed command never carries a value
    `DLLE_ASSERT(a_err_no_value,
                 (done && (status != dlle_pkg::STS_OK)) |-> (result_value == '0),
                 "error result carries a value")

    // the engine is idle and quiet once a reset edge has been seen
    `DLLE_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!busy && !done), "activity in reset")

endmodule

bind doubly_linked_list_engine dlle_checker u_dlle_checker (.*);

// File: test/tb_doubly_linked_list_engine.sv
// Self-checking testbench for the doubly linked list engine.
module tb_doubly_linked_list_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [dlle_pkg::CMD_BITS-1:0] CMD_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 450;

    typedef struct packed {
        dlle_pkg::status_t                sts;
        logic [dlle_pkg::HANDLE_BITS-1:0] hnd;
        logic [dlle_pkg::VALUE_BITS-1:0]  val;
        logic [dlle_pkg::COUNT_BITS-1:0]  cnt;
    } list_result_t;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} traffic_mode_t;

    logic                                    clk = 1'b0;
    logic                                    rst_n = 1'b0;
    logic                                    start = 1'b0;
    logic [dlle_pkg::CMD_BITS-1:0]           cmd = '0;
    logic [dlle_pkg::HANDLE_BITS-1:0]        node_handle = '0;
    logic signed [dlle_pkg::VALUE_BITS-1:0]  value = '0;
    logic                                    busy;
    logic                                    done;
    logic [dlle_pkg::STATUS_BITS-1:0]        status;
    logic [dlle_pkg::HANDLE_BITS-1:0]        result_handle;
    logic signed [dlle_pkg::VALUE_BITS-1:0]  result_value;
    logic [dlle_pkg::COUNT_BITS-1:0]         element_count_out;

    // List mirror: links, values and allocation state
    logic [dlle_pkg::HANDLE_BITS-1:0] link_nxt [dlle_pkg::NODES];
    logic [dlle_pkg::HANDLE_BITS-1:0] link_prv [dlle_pkg::NODES];
    logic [dlle_pkg::VALUE_BITS-1:0]  slot_val [dlle_pkg::NODES];
    logic                             slot_used [dlle_pkg::NODES];
    logic [dlle_pkg::HANDLE_BITS-1:0] free_top;
    logic [dlle_pkg::WM_BITS-1:0]     fresh_mark;
    logic [dlle_pkg::COUNT_BITS-1:0]  elem_cnt;

    list_result_t expected_results [$];
    list_result_t want;
    int errors = 0;
    int issued = 0;
    int cycle_cnt = 0;
    int sts_seen [5];
    int noop_seen = 0;
    bit gaps_on = 1'b1;

    doubly_linked_list_engine dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .cmd              (cmd),
        .node_handle      (node_handle),
        .value            (value),
        .done             (done),
        .status           (status),
        .result_handle    (result_handle),
        .result_value     (result_value),
        .element_count_out(element_count_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void link_new_before(
        input  logic [dlle_pkg::HANDLE_BITS-1:0] pos,
        input  logic [dlle_pkg::VALUE_BITS-1:0]  v,
        output dlle_pkg::status_t                sts,
        output logic [dlle_pkg::HANDLE_BITS-1:0] n);
        logic [dlle_pkg::HANDLE_BITS-1:0] p;
        n = '0;
        // Reuse freed slots first, then take untouched ones
        if (free_top != '0)
        begin
            n = free_top;
            free_top = link_nxt[n];
        end
        else if (fresh_mark < dlle_pkg::NODES)
        begin
            n = fresh_mark[dlle_pkg::HANDLE_BITS-1:0];
            fresh_mark = fresh_mark + 1'b1;
        end
        if (n == '0)
            sts = dlle_pkg::STS_FULL;
        else
        begin
            p = link_prv[pos];
            slot_val[n] = v;
            slot_used[n] = 1'b1;
            link_nxt[n] = pos;
            link_prv[n] = p;
            link_nxt[p] = n;
            link_prv[pos] = n;
            elem_cnt = elem_cnt + 1'b1;
            sts = dlle_pkg::STS_OK;
        end
    endfunction

    function automatic void release_node(input logic [dlle_pkg::HANDLE_BITS-1:0] n);
        logic [dlle_pkg::HANDLE_BITS-1:0] a;
        logic [dlle_pkg::HANDLE_BITS-1:0] b;
        a = link_nxt[n];
        b = link_prv[n];
        link_prv[a] = b;
        link_nxt[b] = a;
        slot_used[n] = 1'b0;
        link_nxt[n] = free_top;
        link_prv[n] = '0;
        free_top = n;
        if (elem_cnt != '0)
            elem_cnt = elem_cnt - 1'b1;
    endfunction

    function automatic list_result_t apply_list_cmd(
        input logic [dlle_pkg::CMD_BITS-1:0]    op,
        input logic [dlle_pkg::HANDLE_BITS-1:0] h,
        input logic [dlle_pkg::VALUE_BITS-1:0]  v);
        list_result_t r;
        logic [dlle_pkg::HANDLE_BITS-1:0] cur;
        int steps;
        r.sts = dlle_pkg::STS_OK;
        r.hnd = '0;
        r.val = '0;
        case (op)
            dlle_pkg::CMD_PUSH_BACK:
                link_new_before('0, v, r.sts, r.hnd);
            dlle_pkg::CMD_PUSH_FRONT:
                link_new_before(link_nxt[0], v, r.sts, r.hnd);
            dlle_pkg::CMD_POP_BACK, dlle_pkg::CMD_POP_FRONT:
            begin
                if (elem_cnt == '0 || link_nxt[0] == '0)
                    r.sts = dlle_pkg::STS_EMPTY;
                else
                begin
                    r.hnd = (op == dlle_pkg::CMD_POP_BACK) ? link_prv[0] : link_nxt[0];
                    r.val = slot_val[r.hnd];
                    release_node(r.hnd);
                end
            end
            dlle_pkg::CMD_INSERT:
            begin
                if (h != '0 && !slot_used[h])
                    r.sts = dlle_pkg::STS_BAD_HANDLE;
                else
                    link_new_before(h, v, r.sts, r.hnd);
            end
            dlle_pkg::CMD_ERASE:
            begin
                if (h == '0 || !slot_used[h])
                    r.sts = dlle_pkg::STS_BAD_HANDLE;
                else
                begin
                    r.hnd = h;
                    r.val = slot_val[h];
                    release_node(h);
                end
            end
            dlle_pkg::CMD_FIND:
            begin
                cur = link_nxt[0];
                steps = 0;
                r.sts = dlle_pkg::STS_NOT_FOUND;
                while (cur != '0 && steps < dlle_pkg::NODES && r.sts != dlle_pkg::STS_OK)
                begin
                    if (slot_val[cur] == v)
                    begin
                        r.sts = dlle_pkg::STS_OK;
                        r.hnd = cur;
                        r.val = v;
                    end
                    cur = link_nxt[cur];
                    steps++;
                end
            end
            default:
                noop_seen++;
        endcase
        r.cnt = elem_cnt;
        sts_seen[r.sts]++;
        return r;
    endfunction

    // Random node currently in the list, 0 when the list is empty
    function automatic logic [dlle_pkg::HANDLE_BITS-1:0] pick_live_handle();
        logic [dlle_pkg::HANDLE_BITS-1:0] cur;
        int k;
        if (elem_cnt == '0)
            return '0;
        k = $urandom_range(elem_cnt - 1);
        cur = link_nxt[0];
        repeat (k)
            cur = link_nxt[cur];
        return cur;
    endfunction

    // Favor small and extreme values so finds hit and duplicates occur
    function automatic logic [dlle_pkg::VALUE_BITS-1:0] pick_value();
        int roll;
        roll = $urandom_range(9);
        case (roll)
            0, 1, 2, 3: return dlle_pkg::VALUE_BITS'($urandom_range(7));
            4:          return {1'b0, {(dlle_pkg::VALUE_BITS-1){1'b1}}};
            5:          return {1'b1, {(dlle_pkg::VALUE_BITS-1){1'b0}}};
            6:          return '1;
            default:    return $urandom;
        endcase
    endfunction

    task automatic send_cmd(input logic [dlle_pkg::CMD_BITS-1:0]    op,
                            input logic [dlle_pkg::HANDLE_BITS-1:0] h,
                            input logic [dlle_pkg::VALUE_BITS-1:0]  v);
        @(posedge clk);
        while (gaps_on && $urandom_range(99) < 35)
            @(posedge clk);
        start <= 1'b1;
        cmd <= op;
        node_handle <= h;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // Transaction taken at this edge
        expected_results.push_back(apply_list_cmd(op, h, v));
        issued++;
        start <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result sts=%0d hnd=%0d val=%h cnt=%0d", $time,
                         status, result_handle, result_value, element_count_out);
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.sts || result_handle !== want.hnd ||
                    result_value !== want.val || element_count_out !== want.cnt)
                begin
                    errors++;
                    $display({"%0t: expected sts=%0d hnd=%0d val=%h cnt=%0d,",
                              " got sts=%0d hnd=%0d val=%h cnt=%0d"},
                             $time, want.sts, want.hnd, want.val, want.cnt,
                             status, result_handle, result_value, element_count_out);
                end
            end
        end
    end

    task automatic test_empty_list();
        send_cmd(dlle_pkg::CMD_POP_BACK, '0, '0);
        send_cmd(dlle_pkg::CMD_POP_FRONT, '1, '1);
        send_cmd(dlle_pkg::CMD_FIND, '0, '0);
        send_cmd(dlle_pkg::CMD_ERASE, '0, '0);
        send_cmd(dlle_pkg::CMD_INSERT, 4'd9, 32'h1234_5678);
        send_cmd(CMD_UNUSED, '1, '1);
    endtask

    task automatic test_fill_to_capacity();
        send_cmd(dlle_pkg::CMD_PUSH_BACK, '0, 32'h7fff_ffff);
        send_cmd(dlle_pkg::CMD_PUSH_FRONT, '0, 32'h8000_0000);
        send_cmd(dlle_pkg::CMD_INSERT, 4'd1, '0);
        send_cmd(dlle_pkg::CMD_INSERT, '0, '1);
        repeat (dlle_pkg::NODES - 5)
            send_cmd($urandom_range(1) ? dlle_pkg::CMD_PUSH_BACK : dlle_pkg::CMD_PUSH_FRONT,
                     '0, pick_value());
        // Pool is full now
        send_cmd(dlle_pkg::CMD_PUSH_BACK, '0, 32'h5555_aaaa);
        send_cmd(dlle_pkg::CMD_INSERT, '1, 32'haaaa_5555);
    endtask

    task automatic test_find_erase_pop();
        send_cmd(dlle_pkg::CMD_FIND, '0, 32'h7fff_ffff);
        send_cmd(dlle_pkg::CMD_FIND, '1, 32'h0bad_f00d);
        send_cmd(dlle_pkg::CMD_ERASE, 4'd3, '0);
        send_cmd(dlle_pkg::CMD_ERASE, 4'd3, '0);
        send_cmd(dlle_pkg::CMD_INSERT, 4'd3, 32'h0000_0042);
        send_cmd(dlle_pkg::CMD_POP_BACK, '0, '0);
        send_cmd(dlle_pkg::CMD_POP_FRONT, '0, '0);
    endtask

    task automatic test_random_traffic(input int total);
        int n_sent;
        int phase;
        int len;
        int roll;
        int grow_lim;
        int shrink_lim;
        traffic_mode_t mode;
        logic [dlle_pkg::CMD_BITS-1:0] op;
        logic [dlle_pkg::HANDLE_BITS-1:0] h;
        logic [dlle_pkg::VALUE_BITS-1:0] v;
        n_sent = 0;
        phase = 0;
        while (n_sent < total)
        begin
            mode = traffic_mode_t'($urandom_range(2));
            len = $urandom_range(20, 60);
            // Run some phases back to back with no gaps
            gaps_on = !(phase == 2 || $urandom_range(7) == 0);
            case (mode)
                MIX_GROW:   begin grow_lim = 65; shrink_lim = 90; end
                MIX_SHRINK: begin grow_lim = 20; shrink_lim = 80; end
                default:    begin grow_lim = 35; shrink_lim = 70; end
            endcase
            repeat (len)
            begin
                roll = $urandom_range(99);
                if (roll < 2)
                    op = CMD_UNUSED;
                else if (roll < grow_lim)
                begin
                    case ($urandom_range(2))
                        0:       op = dlle_pkg::CMD_PUSH_BACK;
                        1:       op = dlle_pkg::CMD_PUSH_FRONT;
                        default: op = dlle_pkg::CMD_INSERT;
                    endcase
                end
                else if (roll < shrink_lim)
                begin
                    case ($urandom_range(2))
                        0:       op = dlle_pkg::CMD_POP_BACK;
                        1:       op = dlle_pkg::CMD_POP_FRONT;
                        default: op = dlle_pkg::CMD_ERASE;
                    endcase
                end
                else
                    op = dlle_pkg::CMD_FIND;

                roll = $urandom_range(99);
                h = dlle_pkg::HANDLE_BITS'($urandom_range(dlle_pkg::NODES - 1));
                if (op == dlle_pkg::CMD_INSERT)
                begin
                    if (roll < 70)
                        h = pick_live_handle();
                    else if (roll < 85)
                        h = '0;
                end
                else if (op == dlle_pkg::CMD_ERASE && roll < 75)
                    h = pick_live_handle();

                v = pick_value();
                if (op == dlle_pkg::CMD_FIND && elem_cnt != '0 && $urandom_range(99) < 60)
                    v = slot_val[pick_live_handle()];

                send_cmd(op, h, v);
                n_sent++;
            end
            phase++;
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb_doubly_linked_list_engine: errors");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < dlle_pkg::NODES; i++)
        begin
            link_nxt[i] = '0;
            link_prv[i] = '0;
            slot_val[i] = '0;
            slot_used[i] = 1'b0;
        end
        for (int i = 0; i < 5; i++)
            sts_seen[i] = 0;
        free_top = '0;
        fresh_mark = dlle_pkg::WM_BITS'(1);
        elem_cnt = '0;

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_fill_to_capacity();
        test_find_erase_pop();
        test_random_traffic(RANDOM_ITEMS);

        while (expected_results.size() != 0)
            @(posedge clk);
        // Catch any stray result after the last one
        repeat (dlle_pkg::NODES + 8)
            @(posedge clk);

        $display("Ran %0d transactions: ok %0d, empty %0d, full %0d, bad handle %0d,",
                 issued, sts_seen[dlle_pkg::STS_OK], sts_seen[dlle_pkg::STS_EMPTY],
                 sts_seen[dlle_pkg::STS_FULL], sts_seen[dlle_pkg::STS_BAD_HANDLE]);
        $display("not found %0d, unused opcode %0d, mismatches %0d",
                 sts_seen[dlle_pkg::STS_NOT_FOUND], noop_seen, errors);
        if (errors == 0)
            $display("tb_doubly_linked_list_engine: clean");
        else
            $display("tb_doubly_linked_list_engine: errors");
        $finish;
    end

endmodule

// File: doubly_linked_list_engine.f
+incdir+rtl
rtl/dlle_pkg.sv
rtl/doubly_linked_list_engine.sv
rtl/dlle_checker.sv
test/tb_doubly_linked_list_engine.sv
